[design/pel_pkg.sv]
// Shared types and constants for the passcode entry lock.
// Used by pel_step, pel_outq and passcode_entry_lock; no dependencies.
`default_nettype none

package pel_pkg;

    localparam int CODE_DIGITS_DEF = 6;
    localparam int PASS_W          = 24;
    localparam int PASS_DIGITS     = PASS_W / 4;
    localparam logic [PASS_W-1:0] PASS_RESET = 24'h123456;

    localparam int OUTQ_DEPTH = 4;

    localparam logic [7:0] KEY_LF   = 8'h0A;
    localparam logic [7:0] KEY_CR   = 8'h0D;
    localparam logic [7:0] KEY_BS   = 8'h08;
    localparam logic [7:0] KEY_DEL  = 8'h7F;
    localparam logic [7:0] KEY_ESC  = 8'h1B;
    localparam logic [7:0] KEY_ZERO = 8'h30;
    localparam logic [7:0] KEY_NINE = 8'h39;

    typedef enum logic [2:0] {
        EV_OPEN   = 3'd0,
        EV_MASK   = 3'd1,
        EV_ERASE  = 3'd2,
        EV_CANCEL = 3'd3,
        EV_GRANT  = 3'd4,
        EV_DENY   = 3'd5
    } t_event;

    typedef struct packed {
        t_event     ev;
        logic [2:0] pos;
        logic       last;
    } t_res;

    // results produced by one key: count (0..2) and the items in order
    typedef struct packed {
        logic [1:0] num;
        t_res       res0;
        t_res       res1;
    } t_push;

endpackage

`default_nettype wire

[design/pel_step.sv]
// Key input register, entry state, digit store and verdict compare.
// Depends on pel_pkg; feeds result items to pel_outq.
`default_nettype none

module pel_step #(
    parameter int CODE_DIGITS = pel_pkg::CODE_DIGITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_key_valid,
    output logic                             o_key_ready,
    input  wire logic [7:0]                  i_key,
    input  wire logic                        i_cfg_valid,
    input  wire logic [pel_pkg::PASS_W-1:0]  i_cfg_data,
    input  wire logic                        i_room,
    output pel_pkg::t_push                   o_push
);
    import pel_pkg::*;

    localparam int CNT_W  = $clog2(CODE_DIGITS + 1);
    localparam int IDX_W  = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
    localparam int WANT_W = (4 * CODE_DIGITS > PASS_W) ? 4 * CODE_DIGITS : PASS_W;

    logic                r_key_vld;
    logic [7:0]          r_key;
    logic                r_active;
    logic                n_active;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [PASS_W-1:0]   r_pass;
    logic [3:0]          r_store [CODE_DIGITS];
    logic                fire;
    logic                store_we;
    logic                match;
    logic [WANT_W-1:0]   want_vec;
    logic [3:0]          cand;
    t_push               push;

    assign fire        = r_key_vld && i_room;
    assign o_key_ready = !r_key_vld || fire;
    assign want_vec    = WANT_W'(r_pass);
    assign o_push      = push;

    // last digit sits in the bottom nibble; leading digits beyond the register compare to zero
    always_comb begin
        match = 1'b1;
        for (int i = 0; i < CODE_DIGITS; i++) begin
            cand = (i == CODE_DIGITS - 1) ? r_key[3:0] : r_store[i];
            if (cand != want_vec[4*(CODE_DIGITS-1-i) +: 4]) begin
                match = 1'b0;
            end
        end
    end

    always_comb begin
        n_active = r_active;
        n_count  = r_count;
        store_we = 1'b0;
        push     = '0;
        if (fire) begin
            if (!r_active) begin
                if (r_key == KEY_LF || r_key == KEY_CR) begin
                    n_active   = 1'b1;
                    n_count    = '0;
                    push.num   = 2'd1;
                    push.res0  = '{ev: EV_OPEN, pos: 3'd0, last: 1'b1};
                end
            end else if (r_key inside {[KEY_ZERO:KEY_NINE]}) begin
                store_we = 1'b1;
                if (r_count == CNT_W'(CODE_DIGITS - 1)) begin
                    n_active  = 1'b0;
                    n_count   = '0;
                    push.num  = 2'd2;
                    push.res0 = '{ev: EV_MASK, pos: 3'(r_count), last: 1'b0};
                    push.res1 = '{ev: (match ? EV_GRANT : EV_DENY), pos: 3'd0, last: 1'b1};
                end else begin
                    n_count   = r_count + CNT_W'(1);
                    push.num  = 2'd1;
                    push.res0 = '{ev: EV_MASK, pos: 3'(r_count), last: 1'b1};
                end
            end else if ((r_key == KEY_DEL || r_key == KEY_BS) && r_count != '0) begin
                n_count   = r_count - CNT_W'(1);
                push.num  = 2'd1;
                push.res0 = '{ev: EV_ERASE, pos: 3'(r_count - CNT_W'(1)), last: 1'b1};
            end else if (r_key == KEY_ESC) begin
                n_active  = 1'b0;
                n_count   = '0;
                push.num  = 2'd1;
                push.res0 = '{ev: EV_CANCEL, pos: 3'd0, last: 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_vld <= 1'b0;
            r_active  <= 1'b0;
            r_count   <= '0;
            r_pass    <= PASS_RESET;
        end else begin
            if (o_key_ready) begin
                r_key_vld <= i_key_valid;
            end
            r_active <= n_active;
            r_count  <= n_count;
            if (i_cfg_valid) begin
                r_pass <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_key_ready && i_key_valid) begin
            r_key <= i_key;
        end
        if (store_we) begin
            r_store[r_count[IDX_W-1:0]] <= r_key[3:0];
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CNT_W'(CODE_DIGITS))
        else $error("digit count out of range");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> r_count == '0)
        else $error("digits held while idle");

    a_hold_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_vld && !i_room |=> r_key_vld && $stable(r_key) && $stable(r_count))
        else $error("stalled key lost or state moved");

endmodule

`default_nettype wire

[design/pel_outq.sv]
// Small result queue: takes up to two result items a cycle, hands out one a beat.
// Depends on pel_pkg.
`default_nettype none

module pel_outq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire pel_pkg::t_push  i_push,
    output logic                 o_room,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output pel_pkg::t_res        o_res
);
    import pel_pkg::*;

    localparam int PTR_W = $clog2(OUTQ_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    t_res             r_mem [OUTQ_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             pop;

    assign o_valid = r_cnt != '0;
    assign pop     = o_valid && i_ready;
    assign o_res   = r_mem[r_rd];
    // room for the worst case of two results from one key
    assign o_room  = r_cnt <= CNT_W'(OUTQ_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + PTR_W'(i_push.num);
            r_rd  <= r_rd + PTR_W'(pop);
            r_cnt <= r_cnt + CNT_W'(i_push.num) - CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[r_wr + PTR_W'(1)] <= i_push.res1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.num != 2'd0 |-> (r_cnt + CNT_W'(i_push.num)) <= CNT_W'(OUTQ_DEPTH))
        else $error("result queue overflow");

    a_num_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.num != 2'd3)
        else $error("more than two results from one key");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_push.num == 2'd0 |=> r_cnt == $past(r_cnt) - CNT_W'(1))
        else $error("queue count did not drop on beat");

endmodule

`default_nettype wire

[design/passcode_entry_lock.sv]
// A key beat is registered, then stepped into the result queue when it has room,
// and its first result beat is offered from the queue's registered storage.
// Throughput: one key per cycle while results are taken; a key with a verdict
// occupies the output for two beats, set by the single-beat result queue port.
// Reset (i_rst_n low, synchronous): idle, no digits, queue empty, passcode 0x123456.
// Digit store is not reset; a verdict only reads digits of the current entry.
`default_nettype none

module passcode_entry_lock #(
    parameter int CODE_DIGITS = pel_pkg::CODE_DIGITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [7:0]                  s_axis_tdata,   // [7:0] key_code
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [7:0]                       m_axis_tdata,   // [2:0] event_res, [5:3] position
    output logic                             m_axis_tlast,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [pel_pkg::PASS_W-1:0]  i_cfg_data     // passcode_bcd
);
    import pel_pkg::*;

    t_push push;
    t_res  res;
    logic  room;

    assign o_cfg_ready = 1'b1;

    pel_step #(
        .CODE_DIGITS (CODE_DIGITS)
    ) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key_valid (s_axis_tvalid),
        .o_key_ready (s_axis_tready),
        .i_key       (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_room      (room),
        .o_push      (push)
    );

    pel_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    assign m_axis_tdata = {2'b00, res.pos, res.ev};
    assign m_axis_tlast = res.last;

endmodule

`default_nettype wire
